// File: rtl/mpr_pkg.sv
`timescale 1ns / 1ps

package mpr_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam logic [7:0] REPLY_BYTES = 8'd13;

    localparam logic [15:0] WRITE_INTERVAL_RST = 16'd5;
    localparam logic [7:0] FIRST_TERMINAL_RST = 8'd1;
    localparam logic [8:0] TERMINAL_COUNT_RST = 9'd1;
    localparam logic [7:0] STATION_ID_RST = 8'd1;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam logic [1:0] CFG_WRITE_INTERVAL = 2'd0;
    localparam logic [1:0] CFG_FIRST_TERMINAL = 2'd1;
    localparam logic [1:0] CFG_TERMINAL_COUNT = 2'd2;

    localparam logic OP_TICK = 1'b0;
    localparam logic OP_REPLY = 1'b1;

    localparam logic KIND_FRAME = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    localparam logic [1:0] VERDICT_WAIT = 2'd0;
    localparam logic [1:0] VERDICT_ACCEPTED = 2'd1;
    localparam logic [1:0] VERDICT_BAD_ADDR = 2'd2;
    localparam logic [1:0] VERDICT_OVERSIZED = 2'd3;

    localparam logic [2:0] IDX_STATION = 3'd0;
    localparam logic [2:0] IDX_CRC_LO = 3'd6;
    localparam logic [2:0] IDX_CRC_HI = 3'd7;

    typedef struct packed {
        logic       is_reply;
        logic [7:0] station;
        logic [1:0] verdict;
    } cmd_t;

    function automatic logic [7:0] body_byte(input logic [2:0] idx);
        logic [7:0] b;
        case (idx)
            3'd1: b = 8'd3;
            3'd2: b = 8'd0;
            3'd3: b = 8'd42;
            3'd4: b = 8'd0;
            3'd5: b = 8'd4;
            default: b = 8'd0;
        endcase
        return b;
    endfunction

    function automatic logic [15:0] crc_step(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {8'd0, b};
        for (int i = 0; i < 8; i++)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

// File: rtl/mpr_front.sv
`timescale 1ns / 1ps

module mpr_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [15:0]       cfg_data,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              op,
    input  logic              port_ready,
    input  logic [7:0]        reply_length,
    input  logic [7:0]        reply_address,
    output logic              push_valid,
    input  logic              push_ready,
    output mpr_pkg::cmd_t     push_cmd
);
    import mpr_pkg::*;

    logic [15:0] write_interval_reg, write_interval_next;
    logic [7:0]  first_terminal_reg, first_terminal_next;
    logic [8:0]  terminal_count_reg, terminal_count_next;
    logic [15:0] tick_count_reg, tick_count_next;
    logic [7:0]  station_id_reg, station_id_next;

    logic        accept;
    logic [15:0] tick_inc;
    logic        due;
    logic        send;
    logic [7:0]  offset;
    logic [8:0]  offset_inc;
    logic [9:0]  range_hi;
    logic        addr_ok;
    logic [1:0]  verdict_val;

    assign cfg_ready = 1'b1;
    assign in_ready  = push_ready;
    assign accept    = in_valid && in_ready;

    // tick counting and id stepping
    assign tick_inc   = (tick_count_reg == 16'hFFFF) ? tick_count_reg : tick_count_reg + 16'd1;
    assign due        = (tick_inc >= write_interval_reg);
    assign send       = due && port_ready;
    assign offset     = station_id_reg - first_terminal_reg;
    assign offset_inc = {1'b0, offset} + 9'd1;

    // reply screening
    assign range_hi = {2'b00, first_terminal_reg} + {1'b0, terminal_count_reg};
    assign addr_ok  = (reply_address >= first_terminal_reg) &&
                      ({2'b00, reply_address} < range_hi);

    always_comb
    begin
        if (reply_length == REPLY_BYTES)
            verdict_val = addr_ok ? VERDICT_ACCEPTED : VERDICT_BAD_ADDR;
        else if (reply_length > REPLY_BYTES)
            verdict_val = VERDICT_OVERSIZED;
        else
            verdict_val = VERDICT_WAIT;
    end

    assign push_valid       = in_valid && ((op == OP_REPLY) || send);
    assign push_cmd.is_reply = (op == OP_REPLY);
    assign push_cmd.station  = station_id_reg;
    assign push_cmd.verdict  = (op == OP_REPLY) ? verdict_val : VERDICT_WAIT;

    always_comb
    begin
        write_interval_next = write_interval_reg;
        first_terminal_next = first_terminal_reg;
        terminal_count_next = terminal_count_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_WRITE_INTERVAL: write_interval_next = cfg_data;
                CFG_FIRST_TERMINAL: first_terminal_next = cfg_data[7:0];
                CFG_TERMINAL_COUNT: terminal_count_next = cfg_data[8:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        tick_count_next = tick_count_reg;
        station_id_next = station_id_reg;
        if (accept && (op == OP_TICK))
        begin
            tick_count_next = due ? 16'd0 : tick_inc;
            if (send)
            begin
                if (offset_inc >= terminal_count_reg)
                    station_id_next = first_terminal_reg;
                else
                    station_id_next = first_terminal_reg + offset_inc[7:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            write_interval_reg <= WRITE_INTERVAL_RST;
            first_terminal_reg <= FIRST_TERMINAL_RST;
            terminal_count_reg <= TERMINAL_COUNT_RST;
            tick_count_reg     <= 16'd0;
            station_id_reg     <= STATION_ID_RST;
        end
        else
        begin
            write_interval_reg <= write_interval_next;
            first_terminal_reg <= first_terminal_next;
            terminal_count_reg <= terminal_count_next;
            tick_count_reg     <= tick_count_next;
            station_id_reg     <= station_id_next;
        end
    end

endmodule

// File: rtl/mpr_queue.sv
`timescale 1ns / 1ps

module mpr_queue #(
    parameter int DEPTH = mpr_pkg::QUEUE_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    output logic          push_ready,
    input  mpr_pkg::cmd_t push_cmd,
    output logic          pop_valid,
    input  logic          pop_ready,
    output mpr_pkg::cmd_t pop_cmd
);
    import mpr_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    cmd_t          mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push;
    logic          do_pop;

    assign push_ready = (count_reg != FULL_CNT);
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PW'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PW'(1);
        if (do_push && !do_pop)
            count_next = count_reg + CW'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: rtl/mpr_back.sv
`timescale 1ns / 1ps

module mpr_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_ready,
    input  mpr_pkg::cmd_t cmd,
    output logic          out_valid,
    input  logic          out_ready,
    output logic          kind,
    output logic [7:0]    frame_byte,
    output logic          last_byte,
    output logic [1:0]    verdict
);
    import mpr_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE  = 2'b01,
        S_FRAME = 2'b10
    } state_t;

    state_t      state_reg, state_next;
    logic [2:0]  idx_reg, idx_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  sid_reg, sid_next;
    logic        out_valid_reg, out_valid_next;
    logic        kind_reg, kind_next;
    logic [7:0]  frame_byte_reg, frame_byte_next;
    logic        last_byte_reg, last_byte_next;
    logic [1:0]  verdict_reg, verdict_next;

    logic        out_free;
    logic [7:0]  cur_byte;

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        case (idx_reg)
            IDX_STATION: cur_byte = sid_reg;
            IDX_CRC_LO:  cur_byte = crc_reg[7:0];
            IDX_CRC_HI:  cur_byte = crc_reg[15:8];
            default:     cur_byte = body_byte(idx_reg);
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        crc_next        = crc_reg;
        sid_next        = sid_reg;
        out_valid_next  = out_valid_reg;
        kind_next       = kind_reg;
        frame_byte_next = frame_byte_reg;
        last_byte_next  = last_byte_reg;
        verdict_next    = verdict_reg;
        cmd_ready       = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b0;
                    if (cmd_valid)
                    begin
                        cmd_ready = 1'b1;
                        if (cmd.is_reply)
                        begin
                            out_valid_next  = 1'b1;
                            kind_next       = KIND_VERDICT;
                            frame_byte_next = 8'd0;
                            last_byte_next  = 1'b0;
                            verdict_next    = cmd.verdict;
                        end
                        else
                        begin
                            sid_next   = cmd.station;
                            idx_next   = IDX_STATION;
                            crc_next   = CRC_INIT;
                            state_next = S_FRAME;
                        end
                    end
                end
            end
            S_FRAME:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    kind_next       = KIND_FRAME;
                    frame_byte_next = cur_byte;
                    last_byte_next  = (idx_reg == IDX_CRC_HI);
                    verdict_next    = VERDICT_WAIT;
                    // crc covers the station id and body only
                    if (idx_reg < IDX_CRC_LO)
                        crc_next = crc_step(crc_reg, cur_byte);
                    idx_next        = idx_reg + 3'd1;
                    if (idx_reg == IDX_CRC_HI)
                        state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        crc_reg        <= crc_next;
        sid_reg        <= sid_next;
        kind_reg       <= kind_next;
        frame_byte_reg <= frame_byte_next;
        last_byte_reg  <= last_byte_next;
        verdict_reg    <= verdict_next;
    end

    assign out_valid  = out_valid_reg;
    assign kind       = kind_reg;
    assign frame_byte = frame_byte_reg;
    assign last_byte  = last_byte_reg;
    assign verdict    = verdict_reg;

endmodule

// File: rtl/modbus_poll_request_generator_unit.sv
// Modbus RTU polling master. Tick items count seconds; when the count reaches
// write_interval and port_ready is set, a read-holding-registers request of
// eight bytes (station id, 3, 0, 42, 0, 4, CRC-16 low, CRC-16 high) is sent
// out, last_byte marking the CRC high byte, and the station id steps round the
// configured range. Reply items give one verdict each. The front accepts one
// item per cycle while the command queue has room; a reply verdict appears
// in the cycle after it leaves the queue. A request holds the byte sequencer
// from its load until the CRC high byte is out, one byte per cycle while the
// output is taken; no new command is taken meanwhile. Configuration writes
// are always taken and must be done while the block is idle.
`timescale 1ns / 1ps

module modbus_poll_request_generator_unit #(
    parameter int QUEUE_DEPTH = mpr_pkg::QUEUE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        op,
    input  logic        port_ready,
    input  logic [7:0]  reply_length,
    input  logic [7:0]  reply_address,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        kind,
    output logic [7:0]  frame_byte,
    output logic        last_byte,
    output logic [1:0]  verdict
);
    import mpr_pkg::*;

    logic push_valid;
    logic push_ready;
    cmd_t push_cmd;
    logic pop_valid;
    logic pop_ready;
    cmd_t pop_cmd;

    mpr_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .op            (op),
        .port_ready    (port_ready),
        .reply_length  (reply_length),
        .reply_address (reply_address),
        .push_valid    (push_valid),
        .push_ready    (push_ready),
        .push_cmd      (push_cmd)
    );

    mpr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd)
    );

    mpr_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (pop_valid),
        .cmd_ready  (pop_ready),
        .cmd        (pop_cmd),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .kind       (kind),
        .frame_byte (frame_byte),
        .last_byte  (last_byte),
        .verdict    (verdict)
    );

endmodule

// File: rtl/mpr_checker.sv
`timescale 1ns / 1ps

module mpr_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       cfg_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic       kind,
    input logic [7:0] frame_byte,
    input logic       last_byte,
    input logic [1:0] verdict
);
    import mpr_pkg::*;

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(frame_byte)
            && $stable(last_byte) && $stable(verdict))
        else $error("result changed while stalled");

    // unused fields stay zero
    a_field_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((kind == KIND_VERDICT) && frame_byte == 8'd0 && !last_byte)
            || ((kind == KIND_FRAME) && verdict == VERDICT_WAIT))
        else $error("unused result field not zero");

    // a request frame streams without gaps until its last byte
    a_frame_gapless: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && (kind == KIND_FRAME) && !last_byte
            |=> out_valid && (kind == KIND_FRAME))
        else $error("gap inside request frame");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
        else $error("configuration write stalled");

endmodule

bind modbus_poll_request_generator_unit mpr_checker u_mpr_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_ready  (cfg_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .kind       (kind),
    .frame_byte (frame_byte),
    .last_byte  (last_byte),
    .verdict    (verdict)
);

// File: tb/tb_modbus_poll_request_generator_unit.sv
`timescale 1ns / 1ps

module tb_modbus_poll_request_generator_unit;

    import mpr_pkg::*;

    localparam logic [1:0] CFG_UNUSED = 2'd3;

    typedef struct {
        logic       op;
        logic       port_ready;
        logic [7:0] reply_length;
        logic [7:0] reply_address;
    } poll_item_t;

    typedef struct {
        logic       kind;
        logic [7:0] frame_byte;
        logic       last_byte;
        logic [1:0] verdict;
    } poll_out_t;

    typedef struct {
        logic [1:0]  index;
        logic [15:0] data;
    } reg_write_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        op = OP_TICK;
    logic        port_ready = 1'b0;
    logic [7:0]  reply_length = '0;
    logic [7:0]  reply_address = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        kind;
    logic [7:0]  frame_byte;
    logic        last_byte;
    logic [1:0]  verdict;

    modbus_poll_request_generator_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .op            (op),
        .port_ready    (port_ready),
        .reply_length  (reply_length),
        .reply_address (reply_address),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .kind          (kind),
        .frame_byte    (frame_byte),
        .last_byte     (last_byte),
        .verdict       (verdict)
    );

    // poller state and registers as the testbench sees them
    logic [15:0] poll_interval = WRITE_INTERVAL_RST;
    logic [7:0]  base_station = FIRST_TERMINAL_RST;
    logic [8:0]  station_span = TERMINAL_COUNT_RST;
    logic [15:0] seconds = '0;
    logic [7:0]  station = STATION_ID_RST;

    poll_item_t pending_items[$];
    poll_out_t  frames_and_verdicts_due[$];
    reg_write_t reg_writes[$];
    poll_item_t on_wire;
    int         gap_left = 0;
    int         burst_left = 0;
    int         stall_mode = 0;
    int         stall_left = 0;
    int         mismatches = 0;

    initial
    begin
        forever #6 clk = ~clk;
    end

    task automatic predict_frame_or_verdict(input poll_item_t it);
        logic [7:0]  frame [8];
        logic [15:0] crc;
        logic [7:0]  offset;
        logic [9:0]  upper;
        poll_out_t   r;
        if (it.op == OP_TICK)
        begin
            if (seconds != 16'hFFFF)
                seconds = seconds + 16'd1;
            if (seconds < poll_interval)
                return;
            seconds = '0;
            if (!it.port_ready)
                return;
            frame[0] = station;
            frame[1] = 8'd3;
            frame[2] = 8'd0;
            frame[3] = 8'd42;
            frame[4] = 8'd0;
            frame[5] = 8'd4;
            crc = 16'hFFFF;
            for (int i = 0; i < 6; i++)
            begin
                crc = crc ^ {8'h00, frame[i]};
                for (int j = 0; j < 8; j++)
                    crc = crc[0] ? ((crc >> 1) ^ 16'hA001) : (crc >> 1);
            end
            frame[6] = crc[7:0];
            frame[7] = crc[15:8];
            for (int i = 0; i < 8; i++)
            begin
                r.kind = KIND_FRAME;
                r.frame_byte = frame[i];
                r.last_byte = (i == 7);
                r.verdict = VERDICT_WAIT;
                frames_and_verdicts_due.push_back(r);
            end
            offset = station - base_station;
            if ({2'b00, offset} + 10'd1 >= {1'b0, station_span})
                station = base_station;
            else
                station = base_station + offset + 8'd1;
        end
        else
        begin
            r.kind = KIND_VERDICT;
            r.frame_byte = 8'd0;
            r.last_byte = 1'b0;
            if (it.reply_length == REPLY_BYTES)
            begin
                upper = {2'b00, base_station} + {1'b0, station_span};
                r.verdict = (it.reply_address >= base_station && {2'b00, it.reply_address} < upper)
                    ? VERDICT_ACCEPTED : VERDICT_BAD_ADDR;
            end
            else if (it.reply_length > REPLY_BYTES)
                r.verdict = VERDICT_OVERSIZED;
            else
                r.verdict = VERDICT_WAIT;
            frames_and_verdicts_due.push_back(r);
        end
    endtask

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            mismatches++;
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
        end
    endfunction

    function automatic void tick(input logic ready);
        pending_items.push_back('{OP_TICK, ready, 8'd0, 8'd0});
    endfunction

    function automatic void reply(input logic [7:0] len, input logic [7:0] addr);
        pending_items.push_back('{OP_REPLY, 1'($urandom_range(0, 1)), len, addr});
    endfunction

    function automatic void queue_reg(input logic [1:0] index, input logic [15:0] data);
        reg_writes.push_back('{index, data});
    endfunction

    function automatic poll_item_t random_poll_item();
        poll_item_t it;
        int         pick;
        it.op = 1'($urandom_range(0, 1));
        it.port_ready = ($urandom_range(0, 6) != 0);
        pick = $urandom_range(0, 9);
        if (pick < 4)
            it.reply_length = REPLY_BYTES;
        else if (pick < 6)
            it.reply_length = $urandom_range(0, 1) ? REPLY_BYTES + 8'd1 : REPLY_BYTES - 8'd1;
        else
            it.reply_length = 8'($urandom_range(0, 255));
        if (station_span != 0 && $urandom_range(0, 9) < 6)
            it.reply_address = base_station + 8'($urandom_range(0, station_span - 1));
        else
            it.reply_address = 8'($urandom_range(0, 255));
        return it;
    endfunction

    task automatic apply_settings(input logic [15:0] iv, input logic [7:0] ft, input logic [8:0] tc);
        queue_reg(CFG_WRITE_INTERVAL, iv);
        queue_reg(CFG_FIRST_TERMINAL, {8'd0, ft});
        queue_reg(CFG_TERMINAL_COUNT, {7'd0, tc});
        do @(negedge clk); while (reg_writes.size() != 0 || cfg_valid);
    endtask

    task automatic drain();
        do @(negedge clk);
        while (pending_items.size() != 0 || in_valid || frames_and_verdicts_due.size() != 0);
        repeat (30) @(negedge clk);
    endtask

    // register write channel
    always @(posedge clk)
    begin
        reg_write_t w;
        if (!rst_n)
            cfg_valid <= 1'b0;
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_WRITE_INTERVAL: poll_interval = cfg_data;
                    CFG_FIRST_TERMINAL: base_station = cfg_data[7:0];
                    CFG_TERMINAL_COUNT: station_span = cfg_data[8:0];
                    default: ;
                endcase
            end
            if (!cfg_valid || cfg_ready)
            begin
                if (reg_writes.size() != 0)
                begin
                    w = reg_writes.pop_front();
                    cfg_valid <= 1'b1;
                    cfg_index <= w.index;
                    cfg_data <= w.data;
                end
                else
                    cfg_valid <= 1'b0;
            end
        end
    end

    // item driver, bursts with random gaps
    always @(posedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && in_ready)
                predict_frame_or_verdict(on_wire);
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0 || pending_items.size() == 0)
                begin
                    if (gap_left > 0)
                        gap_left--;
                    in_valid <= 1'b0;
                end
                else
                begin
                    on_wire = pending_items.pop_front();
                    in_valid <= 1'b1;
                    op <= on_wire.op;
                    port_ready <= on_wire.port_ready;
                    reply_length <= on_wire.reply_length;
                    reply_address <= on_wire.reply_address;
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        burst_left = ($urandom_range(0, 3) == 0) ? 30 : $urandom_range(0, 7);
                        gap_left = $urandom_range(1, 5);
                    end
                end
            end
        end
    end

    // receiver stall pattern
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(8, 60);
        end
        else
            stall_left--;
        case (stall_mode)
            0: out_ready <= 1'b1;
            1: out_ready <= 1'($urandom_range(0, 1));
            2: out_ready <= ($urandom_range(0, 3) == 0);
            default: out_ready <= stall_left[1];
        endcase
    end

    always @(posedge clk)
    begin
        poll_out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (frames_and_verdicts_due.size() == 0)
            begin
                mismatches++;
                $display("%0t: expected no transaction, actual kind %0d byte %0d last %0d verdict %0d",
                         $time, kind, frame_byte, last_byte, verdict);
            end
            else
            begin
                want = frames_and_verdicts_due.pop_front();
                check_field("kind", want.kind, kind);
                check_field("frame_byte", want.frame_byte, frame_byte);
                check_field("last_byte", want.last_byte, last_byte);
                check_field("verdict", want.verdict, verdict);
            end
        end
    end

    initial
    begin
        logic [15:0] iv;
        logic [7:0]  ft;
        logic [8:0]  tc;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: reply screening and a first request
        reply(8'd0, 8'd0);
        reply(REPLY_BYTES - 8'd1, 8'd1);
        reply(REPLY_BYTES, 8'd1);
        reply(REPLY_BYTES, 8'd0);
        reply(REPLY_BYTES, 8'd2);
        reply(REPLY_BYTES + 8'd1, 8'd1);
        reply(8'd255, 8'd255);
        repeat (5) tick(1'b1);
        drain();

        // zero interval, empty range, due tick with port closed
        apply_settings(16'd0, 8'd255, 9'd0);
        tick(1'b0);
        tick(1'b1);
        reply(REPLY_BYTES, 8'd255);
        drain();

        // range running past 255, unused register index
        queue_reg(CFG_UNUSED, 16'hFFFF);
        apply_settings(16'd1, 8'd250, 9'd10);
        repeat (7) tick(1'b1);
        reply(REPLY_BYTES, 8'd255);
        reply(REPLY_BYTES, 8'd3);
        drain();

        // full address range, then interval lowered to the count already reached
        apply_settings(16'hFFFF, 8'd0, 9'd256);
        repeat (2) tick(1'b1);
        reply(REPLY_BYTES, 8'd255);
        drain();
        apply_settings(16'd2, 8'd0, 9'd256);
        tick(1'b1);
        drain();

        repeat (5)
        begin
            iv = ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(1, 4));
            ft = 8'($urandom_range(0, 255));
            case ($urandom_range(0, 7))
                0: tc = 9'd0;
                1: tc = 9'd256;
                2: tc = 9'd256 - {1'b0, ft};
                3: tc = 9'($urandom_range(1, 256));
                default: tc = 9'($urandom_range(1, 16));
            endcase
            apply_settings(iv, ft, tc);
            repeat (16) pending_items.push_back(random_poll_item());
            drain();
        end

        if (mismatches == 0)
            $display("[modbus_poll_request_generator_unit] OK");
        else
            $display("[modbus_poll_request_generator_unit] ERROR");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("[modbus_poll_request_generator_unit] ERROR");
        $finish;
    end

endmodule
